// ----- hw/rtl/dmbcc_pkg.sv -----
`timescale 1ns / 1ps

package dmbcc_pkg;

  // cache geometry, fixed by the port widths
  localparam int LINES      = 128;
  localparam int ZONE_BYTES = 1024;
  localparam int IDX_W      = $clog2(LINES);

  // request modes
  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_SYNC  = 2'd2;

  typedef enum logic [1:0] {
    ST_INVALID = 2'd0,
    ST_CLEAN   = 2'd1,
    ST_DIRTY   = 2'd2
  } line_status_t;

  typedef enum logic [1:0] {
    KIND_WB        = 2'd0,
    KIND_FILL      = 2'd1,
    KIND_GRANT     = 2'd2,
    KIND_SYNC_DONE = 2'd3
  } kind_t;

  typedef struct packed {
    line_status_t status;
    logic [7:0]   drive;
    logic [30:0]  zone;
  } entry_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_LOOKUP,
    S_CHECK,
    S_WB,
    S_FILL,
    S_GRANT,
    S_REJECT,
    S_SYNC_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic  clr_we;
    logic  capture;
    logic  rd_en;
    logic  wr_grant;
    logic  wr_sync;
    logic  emit;
    kind_t kind;
    logic  reject;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] mode;
    logic       offset_bad;
    logic       sync_oob;
    logic       hit;
    logic       dirty;
    logic       clear_last;
  } sts_t;

endpackage

// ----- hw/rtl/dmbcc_ctrl.sv -----
`timescale 1ns / 1ps

module dmbcc_ctrl import dmbcc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.kind = KIND_GRANT;
    busy = 1'b1;
    case (state)
      S_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.mode)
          MODE_SYNC:  state_next = sts.sync_oob ? S_SYNC_DONE : S_LOOKUP;
          MODE_READ,
          MODE_WRITE: state_next = sts.offset_bad ? S_REJECT : S_LOOKUP;
          default:    state_next = S_IDLE;
        endcase
      end
      S_LOOKUP: begin
        cmd.rd_en = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (sts.mode == MODE_SYNC) begin
          state_next = sts.dirty ? S_WB : S_SYNC_DONE;
        end else if (sts.hit) begin
          state_next = S_GRANT;
        end else begin
          state_next = sts.dirty ? S_WB : S_FILL;
        end
      end
      S_WB: begin
        cmd.emit = 1'b1;
        cmd.kind = KIND_WB;
        if (sts.mode == MODE_SYNC) begin
          cmd.wr_sync = 1'b1;
          state_next = S_SYNC_DONE;
        end else begin
          state_next = S_FILL;
        end
      end
      S_FILL: begin
        cmd.emit = 1'b1;
        cmd.kind = KIND_FILL;
        state_next = S_GRANT;
      end
      S_GRANT: begin
        cmd.emit = 1'b1;
        cmd.kind = KIND_GRANT;
        cmd.wr_grant = 1'b1;
        state_next = S_IDLE;
      end
      S_REJECT: begin
        cmd.emit = 1'b1;
        cmd.kind = KIND_GRANT;
        cmd.reject = 1'b1;
        state_next = S_IDLE;
      end
      S_SYNC_DONE: begin
        cmd.emit = 1'b1;
        cmd.kind = KIND_SYNC_DONE;
        state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

// ----- hw/rtl/dmbcc_datapath.sv -----
`timescale 1ns / 1ps

module dmbcc_datapath import dmbcc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [1:0]  mode,
  input  logic [7:0]  drive,
  input  logic [30:0] zone,
  input  logic [15:0] byte_offset,
  input  logic [15:0] byte_count,
  input  logic [6:0]  sync_line,
  output logic        result_valid,
  output logic [1:0]  kind,
  output logic [7:0]  cmd_drive,
  output logic [31:0] sector,
  output logic [6:0]  line_index,
  output logic [16:0] byte_address,
  output logic [10:0] granted_count,
  output logic        last
);

  localparam int ADDR_W = IDX_W + 14;

  // captured request
  logic [1:0]  mode_r;
  logic [7:0]  drive_r;
  logic [30:0] zone_r;
  logic [15:0] off_r;
  logic [15:0] cnt_r;
  logic [6:0]  sl_r;

  logic [IDX_W-1:0] line;
  logic [IDX_W-1:0] clr_cnt;

  entry_t mem [LINES];
  entry_t rd;
  entry_t wr_data;
  logic [IDX_W-1:0] wr_addr;
  logic             wr_en;

  logic             hit;
  logic [16:0]      sum;
  logic [15:0]      clip;
  logic [ADDR_W-1:0] addr_full;

  logic [1:0]  kind_next;
  logic [7:0]  cmd_drive_next;
  logic [31:0] sector_next;
  logic [6:0]  line_index_next;
  logic [16:0] byte_address_next;
  logic [10:0] granted_count_next;
  logic        last_next;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r  <= mode;
      drive_r <= drive;
      zone_r  <= zone;
      off_r   <= byte_offset;
      cnt_r   <= byte_count;
      sl_r    <= sync_line;
    end
  end

  // line index: zone mod LINES, or the sync line
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      line <= (mode == MODE_SYNC) ? IDX_W'(sync_line) : zone[IDX_W-1:0];
    end
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_we) begin
      clr_cnt <= clr_cnt + IDX_W'(1);
    end
  end

  // tag memory
  always_comb begin
    wr_en   = cmd.clr_we | cmd.wr_grant | cmd.wr_sync;
    wr_addr = cmd.clr_we ? clr_cnt : line;
    wr_data = rd;
    if (cmd.clr_we) begin
      wr_data = '0;
    end else if (cmd.wr_sync) begin
      wr_data.status = ST_CLEAN;
    end else begin
      wr_data.drive = drive_r;
      wr_data.zone  = zone_r;
      if (mode_r == MODE_WRITE) wr_data.status = ST_DIRTY;
      else if (!hit)            wr_data.status = ST_CLEAN;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) rd <= mem[line];
  end

  assign hit = (rd.status != ST_INVALID) && (rd.drive == drive_r) && (rd.zone == zone_r);

  assign sts.mode       = mode_r;
  assign sts.offset_bad = {1'b0, off_r} >= 17'(ZONE_BYTES);
  assign sts.sync_oob   = 32'(sl_r) >= 32'(LINES);
  assign sts.hit        = hit;
  assign sts.dirty      = (rd.status == ST_DIRTY);
  assign sts.clear_last = (clr_cnt == IDX_W'(LINES - 1));

  // grant arithmetic
  assign sum  = {1'b0, off_r} + {1'b0, cnt_r};
  assign clip = (sum > 17'(ZONE_BYTES)) ? (16'(ZONE_BYTES) - off_r) : cnt_r;
  assign addr_full = ADDR_W'(line) * ADDR_W'(ZONE_BYTES) + ADDR_W'(off_r);

  // result word contents
  always_comb begin
    kind_next          = cmd.kind;
    cmd_drive_next     = '0;
    sector_next        = '0;
    line_index_next    = 7'(line);
    byte_address_next  = '0;
    granted_count_next = '0;
    last_next          = 1'b0;
    case (cmd.kind)
      KIND_WB: begin
        cmd_drive_next = rd.drive;
        sector_next    = {rd.zone, 1'b0};
      end
      KIND_FILL: begin
        cmd_drive_next = drive_r;
        sector_next    = {zone_r, 1'b0};
      end
      KIND_GRANT: begin
        last_next = 1'b1;
        if (cmd.reject) begin
          line_index_next = '0;
        end else begin
          byte_address_next  = addr_full[16:0];
          granted_count_next = clip[10:0];
        end
      end
      KIND_SYNC_DONE: begin
        last_next       = 1'b1;
        line_index_next = sl_r;
      end
      default: last_next = 1'b0;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      kind          <= kind_next;
      cmd_drive     <= cmd_drive_next;
      sector        <= sector_next;
      line_index    <= line_index_next;
      byte_address  <= byte_address_next;
      granted_count <= granted_count_next;
      last          <= last_next;
    end
  end

endmodule

// ----- hw/rtl/direct_mapped_block_cache_controller_top.sv -----
`timescale 1ns / 1ps

// direct-mapped write-back tag controller for a disk block cache. a word is
// taken at a clock edge where start is high and busy is low; every result word
// shows for exactly one cycle with result_valid high and cannot be held off,
// so the receiver must take each one as it comes. an item gives one to three
// result words, the final one with last set; a mode 3 item gives none. after
// reset the block runs a clearing pass over all LINES (128) entries of the
// tag memory, holding busy high. an item keeps busy high from accept until
// it is through: a decode state after accept, then, unless the item is
// rejected, of mode 3 or a sync of an out-of-range line, a tag memory read
// with a registered result, then its result words, one per cycle.
module direct_mapped_block_cache_controller_top import dmbcc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // request side
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [7:0]  drive,
  input  logic [30:0] zone,
  input  logic [15:0] byte_offset,
  input  logic [15:0] byte_count,
  input  logic [6:0]  sync_line,
  // result side
  output logic        result_valid,
  output logic [1:0]  kind,
  output logic [7:0]  cmd_drive,
  output logic [31:0] sector,
  output logic [6:0]  line_index,
  output logic [16:0] byte_address,
  output logic [10:0] granted_count,
  output logic        last
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: tag clearing, lookup, writeback, fill, grant, reject and sync done
  dmbcc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // request registers, index, tag memory and result register
  dmbcc_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .mode          (mode),
    .drive         (drive),
    .zone          (zone),
    .byte_offset   (byte_offset),
    .byte_count    (byte_count),
    .sync_line     (sync_line),
    .result_valid  (result_valid),
    .kind          (kind),
    .cmd_drive     (cmd_drive),
    .sector        (sector),
    .line_index    (line_index),
    .byte_address  (byte_address),
    .granted_count (granted_count),
    .last          (last)
  );

  // an accepted word always keeps the block busy for the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy low right after accept");

  // the final word of an item is never directly followed by another word
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |=> !result_valid)
    else $error("word right after last");

  // a fill is always followed by its grant
  a_fill_grant: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind == KIND_FILL |=> result_valid && kind == KIND_GRANT && last)
    else $error("fill without grant");

  // a writeback is always followed by a fill or a sync done
  a_wb_next: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind == KIND_WB |=> result_valid &&
      (kind == KIND_FILL || kind == KIND_SYNC_DONE))
    else $error("writeback not followed by fill or sync done");

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

import dmbcc_pkg::*;

typedef struct packed {
  kind_t       kind;
  logic [7:0]  cmd_drive;
  logic [31:0] sector;
  logic [6:0]  line_index;
  logic [16:0] byte_address;
  logic [10:0] granted_count;
  logic        last;
} cache_word_t;

class cache_tag_mirror;
  localparam int NLINES = 128;
  localparam int ZBYTES = 1024;
  localparam logic [1:0] MODE_NONE = 2'd3;

  line_status_t line_state[NLINES];
  logic [7:0]   drive_tag[NLINES];
  logic [30:0]  zone_tag[NLINES];
  cache_word_t  pending_words[$];
  int           mismatches;

  function new();
    foreach (line_state[i]) line_state[i] = ST_INVALID;
    mismatches = 0;
  endfunction

  function cache_word_t make_word(kind_t k, logic [7:0] d, logic [31:0] s, logic [6:0] l,
                                  logic [16:0] a, logic [10:0] c, logic lst);
    cache_word_t w;
    w.kind = k;
    w.cmd_drive = d;
    w.sector = s;
    w.line_index = l;
    w.byte_address = a;
    w.granted_count = c;
    w.last = lst;
    return w;
  endfunction

  // works out the result words of one accepted request and updates the tags
  function void note_request(logic [1:0] m, logic [7:0] drv, logic [30:0] zn,
                             logic [15:0] off, logic [15:0] cnt, logic [6:0] sl);
    int unsigned clipped;
    int unsigned idx;
    bit hit;
    if (m == MODE_SYNC) begin
      if (int'(sl) < NLINES && line_state[sl] == ST_DIRTY) begin
        pending_words.push_back(make_word(KIND_WB, drive_tag[sl], {zone_tag[sl], 1'b0},
                                          sl, '0, '0, 1'b0));
        line_state[sl] = ST_CLEAN;
      end
      pending_words.push_back(make_word(KIND_SYNC_DONE, '0, '0, sl, '0, '0, 1'b1));
      return;
    end
    if (m == MODE_NONE) return;
    if (int'(off) >= ZBYTES) begin
      pending_words.push_back(make_word(KIND_GRANT, '0, '0, '0, '0, '0, 1'b1));
      return;
    end
    clipped = cnt;
    if (int'(off) + int'(cnt) > ZBYTES) clipped = ZBYTES - off;
    idx = zn % NLINES;
    hit = line_state[idx] != ST_INVALID && drive_tag[idx] == drv && zone_tag[idx] == zn;
    if (!hit) begin
      if (line_state[idx] == ST_DIRTY)
        pending_words.push_back(make_word(KIND_WB, drive_tag[idx], {zone_tag[idx], 1'b0},
                                          7'(idx), '0, '0, 1'b0));
      pending_words.push_back(make_word(KIND_FILL, drv, {zn, 1'b0}, 7'(idx), '0, '0, 1'b0));
      line_state[idx] = ST_CLEAN;
      drive_tag[idx] = drv;
      zone_tag[idx] = zn;
    end
    if (m == MODE_WRITE) line_state[idx] = ST_DIRTY;
    pending_words.push_back(make_word(KIND_GRANT, '0, '0, 7'(idx),
                                      17'(idx * ZBYTES + off), 11'(clipped), 1'b1));
  endfunction

  function void check_word(cache_word_t got);
    cache_word_t want;
    if (pending_words.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result word: kind %0d line %0d last %0d",
                 got.kind, got.line_index, got.last);
      return;
    end
    want = pending_words.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("result mismatch at %0t", $time);
        $display("  want kind %0d drv %h sec %h line %0d addr %h cnt %0d last %0d",
                 want.kind, want.cmd_drive, want.sector, want.line_index,
                 want.byte_address, want.granted_count, want.last);
        $display("  got  kind %0d drv %h sec %h line %0d addr %h cnt %0d last %0d",
                 got.kind, got.cmd_drive, got.sector, got.line_index,
                 got.byte_address, got.granted_count, got.last);
      end
    end
  endfunction
endclass

module tb;
  localparam int MAX_CYCLES = 300000;
  localparam int RANDOM_WORDS = 256;
  // mode code that the block must ignore
  localparam logic [1:0] MODE_NONE = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  mode = MODE_READ;
  logic [7:0]  drive = '0;
  logic [30:0] zone = '0;
  logic [15:0] byte_offset = '0;
  logic [15:0] byte_count = '0;
  logic [6:0]  sync_line = '0;
  logic        result_valid;
  logic [1:0]  kind;
  logic [7:0]  cmd_drive;
  logic [31:0] sector;
  logic [6:0]  line_index;
  logic [16:0] byte_address;
  logic [10:0] granted_count;
  logic        last;

  cache_tag_mirror mirror = new();

  // idling control: bursts come only while idle_on, never in the tail
  bit idle_on = 1'b1;
  bit tail_phase = 1'b0;
  int cycle_count = 0;

  // zones that collide on a few lines, so hits, dirty victims and syncs are common
  logic [30:0] zone_pool[12];
  logic [7:0]  drive_pool[3];
  logic [6:0]  hot_lines[4] = '{7'd0, 7'd127, 7'd37, 7'd90};

  direct_mapped_block_cache_controller_top dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .drive(drive),
    .zone(zone),
    .byte_offset(byte_offset),
    .byte_count(byte_count),
    .sync_line(sync_line),
    .result_valid(result_valid),
    .kind(kind),
    .cmd_drive(cmd_drive),
    .sector(sector),
    .line_index(line_index),
    .byte_address(byte_address),
    .granted_count(granted_count),
    .last(last)
  );

  always #4 clk = ~clk;

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("direct_mapped_block_cache_controller_top verification failed");
      $finish;
    end
  end

  // every result word is taken the cycle it shows; no back-pressure exists
  always @(posedge clk) begin
    if (!rst && result_valid)
      mirror.check_word('{kind_t'(kind), cmd_drive, sector, line_index,
                          byte_address, granted_count, last});
  end

  // start low, with junk on the fields so nothing leaks through
  task automatic idle_burst(int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
      mode <= 2'($urandom);
      drive <= 8'($urandom);
      zone <= 31'($urandom);
      byte_offset <= 16'($urandom);
      byte_count <= 16'($urandom);
      sync_line <= 7'($urandom);
    end
  endtask

  // present one word and hold it until the block takes it
  task automatic send_word(logic [1:0] m, logic [7:0] drv, logic [30:0] zn,
                           logic [15:0] off, logic [15:0] cnt, logic [6:0] sl);
    if ($urandom_range(0, 29) == 0) idle_on = !idle_on;
    if (!tail_phase && idle_on && $urandom_range(0, 2) == 0)
      idle_burst($urandom_range(1, 19));
    @(negedge clk);
    start <= 1'b1;
    mode <= m;
    drive <= drv;
    zone <= zn;
    byte_offset <= off;
    byte_count <= cnt;
    sync_line <= sl;
    // busy is sampled before the edge updates it
    do begin
      @(posedge clk);
    end while (busy);
    mirror.note_request(m, drv, zn, off, cnt, sl);
  endtask

  // request with content drawn from the collision pools
  task automatic pooled_request();
    logic [15:0] off;
    logic [15:0] cnt;
    int r;
    r = $urandom_range(0, 9);
    off = (r == 0) ? 16'd0 : (r == 1) ? 16'(ZONE_BYTES - 1) : 16'($urandom_range(0, 1023));
    r = $urandom_range(0, 9);
    if (r == 0) cnt = 16'd0;
    else if (r == 1) cnt = 16'hffff;
    else if (r < 5) cnt = 16'($urandom);
    else cnt = 16'($urandom_range(0, ZONE_BYTES));
    send_word($urandom_range(0, 1) ? MODE_WRITE : MODE_READ,
              drive_pool[$urandom_range(0, 2)], zone_pool[$urandom_range(0, 11)],
              off, cnt, 7'($urandom));
  endtask

  initial begin
    int issued;
    int pick;
    int run_len;
    logic [6:0] first_line;

    drive_pool[0] = 8'h00;
    drive_pool[1] = 8'hff;
    drive_pool[2] = 8'($urandom);
    foreach (zone_pool[i]) zone_pool[i] = {24'($urandom), hot_lines[i % 4]};

    // reset once; the block then clears its tags while holding busy
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part
    // offsets past the zone end give an empty grant
    send_word(MODE_READ, 8'h12, 31'd5, 16'd1024, 16'd16, 7'd0);
    send_word(MODE_WRITE, 8'hff, 31'h7fffffff, 16'hffff, 16'hffff, 7'h7f);
    // zero-length write still fills and dirties the line
    send_word(MODE_WRITE, 8'h00, 31'd0, 16'd0, 16'd0, 7'd0);
    // hit with a full-zone count
    send_word(MODE_READ, 8'h00, 31'd0, 16'd0, 16'd1024, 7'd0);
    // same line, other zone: dirty victim goes out first
    send_word(MODE_READ, 8'h00, 31'd128, 16'd512, 16'd600, 7'd0);
    // clipped to one byte at the top of the zone
    send_word(MODE_WRITE, 8'hff, 31'h7fffffff, 16'd1023, 16'hffff, 7'd0);
    // sync of dirty, then clean, then invalid lines
    send_word(MODE_SYNC, 8'h00, 31'd0, 16'd0, 16'd0, 7'h7f);
    send_word(MODE_SYNC, 8'h00, 31'd0, 16'd0, 16'd0, 7'h7f);
    send_word(MODE_SYNC, 8'hff, 31'h7fffffff, 16'hffff, 16'hffff, 7'd5);
    // ignored mode gives nothing
    send_word(MODE_NONE, 8'hff, 31'h7fffffff, 16'd0, 16'd4, 7'd0);
    // clean victim is dropped without a writeback
    send_word(MODE_WRITE, 8'hff, 31'h7fffff80, 16'd1, 16'd1023, 7'd0);
    // drive mismatch on the same zone misses
    send_word(MODE_WRITE, 8'h01, 31'h7fffff80, 16'd100, 16'd924, 7'd0);
    send_word(MODE_READ, 8'h01, 31'h7fffff80, 16'd100, 16'd925, 7'd0);
    send_word(MODE_SYNC, 8'h00, 31'd0, 16'd0, 16'd0, 7'd0);
    send_word(MODE_READ, 8'hff, 31'h7fffff80, 16'd1023, 16'd0, 7'd0);
    send_word(MODE_WRITE, 8'h5a, 31'h2aaaaaaa, 16'd1024, 16'd0, 7'd0);

    // random part
    issued = 0;
    while (issued < RANDOM_WORDS) begin
      tail_phase = issued >= RANDOM_WORDS - 40;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        pooled_request();
        issued++;
      end else if (pick < 60) begin
        send_word($urandom_range(0, 1) ? MODE_WRITE : MODE_READ, 8'($urandom),
                  31'($urandom), 16'($urandom_range(0, 1023)), 16'($urandom), 7'($urandom));
        issued++;
      end else if (pick < 67) begin
        // rejected offset
        send_word($urandom_range(0, 1) ? MODE_WRITE : MODE_READ, 8'($urandom),
                  31'($urandom), 16'($urandom_range(ZONE_BYTES, 65535)), 16'($urandom),
                  7'($urandom));
        issued++;
      end else if (pick < 82) begin
        send_word(MODE_SYNC, 8'($urandom), 31'($urandom), 16'($urandom), 16'($urandom),
                  $urandom_range(0, 1) ? hot_lines[$urandom_range(0, 3)] : 7'($urandom));
        issued++;
      end else if (pick < 87) begin
        // ignored, does not count
        send_word(MODE_NONE, 8'($urandom), 31'($urandom), 16'($urandom), 16'($urandom),
                  7'($urandom));
      end else begin
        // partial flush: a run of consecutive line syncs
        run_len = $urandom_range(4, 16);
        first_line = $urandom_range(0, 1) ? 7'($urandom) : hot_lines[$urandom_range(0, 3)];
        for (int k = 0; k < run_len; k++) begin
          send_word(MODE_SYNC, 8'($urandom), 31'($urandom), 16'($urandom), 16'($urandom),
                    7'(first_line + k));
          issued++;
        end
      end
    end

    @(negedge clk);
    start <= 1'b0;

    // drain, then give the block time to show any stray word
    while (mirror.pending_words.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (mirror.mismatches == 0 && mirror.pending_words.size() == 0)
      $display("direct_mapped_block_cache_controller_top verification clean");
    else
      $display("direct_mapped_block_cache_controller_top verification failed");
    $finish;
  end
endmodule

// ----- filelist.f -----
hw/rtl/dmbcc_pkg.sv
hw/rtl/dmbcc_ctrl.sv
hw/rtl/dmbcc_datapath.sv
hw/rtl/direct_mapped_block_cache_controller_top.sv
verif/tb.sv
